/* design/led_matrix_scan_framebuffer_macros.svh */
// Assertion macros shared by the LED matrix scan framebuffer modules.
`ifndef LED_MATRIX_SCAN_FRAMEBUFFER_MACROS_SVH
`define LED_MATRIX_SCAN_FRAMEBUFFER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define LMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising clock edge outside reset.
`define LMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define LMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/lms_pkg.sv */
// Shared constants, operation codes and control types of the LED matrix scan framebuffer.
`timescale 1ns / 1ps
package lms_pkg;

    // Default panel geometry.
    localparam int PANEL_WIDTH_DEF  = 64;
    localparam int PANEL_HEIGHT_DEF = 32;

    // Fixed field widths of the request and scan words.
    localparam int OP_W       = 2;
    localparam int X_W        = 6;
    localparam int Y_W        = 5;
    localparam int COLOR_W    = 2;
    localparam int CELL_W     = 4;
    localparam int ROW_ADDR_W = 4;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_SWAP  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clear_back;
        logic swap;
        logic cell_rd;
        logic cell_wr;
        logic fill_wr;
        logic set_row_valid;
        logic scan_rd;
        logic scan_load;
        logic scan_done;
    } lms_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_range;
        logic            row_valid;
        logic            col_last;
        logic            out_free;
    } lms_status_t;

endpackage

/* design/lms_if.sv */
// Valid/ready channel interfaces for request words and scan words.
`timescale 1ns / 1ps

// Request channel: one operation with its pixel operands per word.
interface lms_req_if;
    logic                         valid;
    logic                         ready;
    logic [lms_pkg::OP_W-1:0]     operation;
    logic [lms_pkg::X_W-1:0]      x;
    logic [lms_pkg::Y_W-1:0]      y;
    logic [lms_pkg::COLOR_W-1:0]  color;

    modport source (output valid, output operation, output x, output y, output color,
                    input ready);
    modport sink   (input valid, input operation, input x, input y, input color,
                    output ready);
endinterface

// Scan channel: one column of shift data per word.
interface lms_scan_if;
    logic                           valid;
    logic                           ready;
    logic [lms_pkg::CELL_W-1:0]     pixel_bits;
    logic [lms_pkg::ROW_ADDR_W-1:0] row_address;
    logic                           last;

    modport source (output valid, output pixel_bits, output row_address, output last,
                    input ready);
    modport sink   (input valid, input pixel_bits, input row_address, input last,
                    output ready);
endinterface

/* design/lms_ctrl.sv */
// Controller state machine that sequences requests, row fills and scan reads.
`timescale 1ns / 1ps
`include "led_matrix_scan_framebuffer_macros.svh"
module lms_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lms_pkg::lms_status_t status,
    output lms_pkg::lms_cmd_t    cmd
);
    import lms_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_FILL   = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       pend_reg;
    logic       pend_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (status.op)
                    OP_TICK:
                    begin
                        state_next = S_SCAN;
                    end
                    OP_WRITE:
                    begin
                        if (!status.in_range)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (status.row_valid)
                        begin
                            cmd.cell_rd = 1'b1;
                            state_next  = S_WRITE;
                        end
                        else
                        begin
                            state_next = S_FILL;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear_back = 1'b1;
                        state_next     = S_IDLE;
                    end
                    OP_SWAP:
                    begin
                        cmd.swap   = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FILL:
            begin
                // Zero the row one cell a cycle, placing the new color on the way.
                cmd.fill_wr = 1'b1;
                if (status.col_last)
                begin
                    cmd.set_row_valid = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_WRITE:
            begin
                cmd.cell_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                // A read is issued whenever its data is sure to find room.
                cmd.scan_load = pend_reg && status.out_free;
                cmd.scan_rd   = !pend_reg || status.out_free;
                if (cmd.scan_rd)
                begin
                    pend_next = 1'b1;
                    if (status.col_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (pend_reg && status.out_free)
                begin
                    cmd.scan_load = 1'b1;
                    cmd.scan_done = 1'b1;
                    pend_next     = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                pend_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    `LMS_ASSERT_NEXT(a_accept_decode, clk, rst_n, in_valid && in_ready, state_reg == S_DECODE, "accepted word not decoded next")
    `LMS_ASSERT_IMPLY(a_drain_pend, clk, rst_n, state_reg == S_DRAIN, pend_reg, "drain without pending read data")
    `LMS_ASSERT_NEXT(a_pend_hold, clk, rst_n, pend_reg && !status.out_free, pend_reg, "pending read data lost while output stalled")

endmodule

/* design/lms_dpath.sv */
// Datapath with the double frame store, row valid bits, scan row counter and output register.
`timescale 1ns / 1ps
`include "led_matrix_scan_framebuffer_macros.svh"
module lms_dpath #(
    parameter int PANEL_WIDTH  = lms_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = lms_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lms_pkg::lms_cmd_t              cmd,
    output lms_pkg::lms_status_t           status,
    input  logic [lms_pkg::OP_W-1:0]       operation,
    input  logic [lms_pkg::X_W-1:0]        x,
    input  logic [lms_pkg::Y_W-1:0]        y,
    input  logic [lms_pkg::COLOR_W-1:0]    color,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lms_pkg::CELL_W-1:0]     pixel_bits,
    output logic [lms_pkg::ROW_ADDR_W-1:0] row_address,
    output logic                           last
);
    import lms_pkg::*;

    localparam int SCAN_ROWS = PANEL_HEIGHT / 2;
    localparam int COL_W     = $clog2(PANEL_WIDTH);
    localparam int ROW_W     = $clog2(SCAN_ROWS);
    localparam int ADDR_W    = 1 + ROW_W + COL_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int VLD_N     = 2 ** (1 + ROW_W);
    localparam int ROWS_P2   = 2 ** ROW_W;
    localparam int XC_W      = COL_W + X_W + 1;
    localparam int YC_W      = ROW_W + Y_W + 2;
    localparam int RA_W      = ROW_ADDR_W + ROW_W;

    // Put a color into the upper-half or lower-half bits of a cell.
    function automatic logic [CELL_W-1:0] merge_cell(input logic [CELL_W-1:0] old_cell,
                                                     input logic second_half,
                                                     input logic [COLOR_W-1:0] c);
        logic [CELL_W-1:0] res;
        if (second_half)
        begin
            res = {c, old_cell[1:0]};
        end
        else
        begin
            res = {old_cell[3:2], c};
        end
        return res;
    endfunction

    logic [CELL_W-1:0]     mem [MEM_DEPTH];

    logic [OP_W-1:0]       op_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic [COL_W-1:0]      col_t_reg;
    logic [ROW_W-1:0]      row_t_reg;
    logic                  half_reg;
    logic                  in_range_reg;
    logic [CELL_W-1:0]     rd_data_reg;
    logic                  rd_last_reg;
    logic [CELL_W-1:0]     out_bits_reg;
    logic [ROW_ADDR_W-1:0] out_row_reg;
    logic                  out_last_reg;

    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      col_next;
    logic                  front_reg;
    logic                  front_next;
    logic [ROW_W-1:0]      scan_row_reg;
    logic [ROW_W-1:0]      scan_row_next;
    logic [VLD_N-1:0]      row_valid_reg;
    logic [VLD_N-1:0]      row_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic [XC_W-1:0]       x_ext;
    logic [YC_W-1:0]       y_ext;
    logic [YC_W-1:0]       y_row;
    logic                  y_half;
    logic                  back;
    logic                  col_last;
    logic                  out_free;
    logic                  back_row_valid;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [CELL_W-1:0]     wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [CELL_W-1:0]     scan_bits;
    logic [RA_W-1:0]       ra_ext;

    // Request operand decode: widening of x and y and split of y into row and half.
    always_comb
    begin
        x_ext  = XC_W'(x);
        y_ext  = YC_W'(y);
        y_half = y_ext >= YC_W'(SCAN_ROWS);
        y_row  = y_half ? y_ext - YC_W'(SCAN_ROWS) : y_ext;
    end

    // Captured request operands.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= operation;
            color_reg    <= color;
            col_t_reg    <= x_ext[COL_W-1:0];
            row_t_reg    <= y_row[ROW_W-1:0];
            half_reg     <= y_half;
            in_range_reg <= (x_ext < XC_W'(PANEL_WIDTH)) && (y_ext < YC_W'(PANEL_HEIGHT));
        end
    end

    assign back           = ~front_reg;
    assign col_last       = col_reg == COL_W'(PANEL_WIDTH - 1);
    assign out_free       = !out_valid_reg || out_ready;
    assign back_row_valid = row_valid_reg[{back, row_t_reg}];

    // Memory port selection.
    always_comb
    begin
        wr_en = cmd.cell_wr || cmd.fill_wr;
        rd_en = cmd.cell_rd || cmd.scan_rd;
        if (cmd.cell_wr)
        begin
            wr_addr = {back, row_t_reg, col_t_reg};
            wr_data = merge_cell(rd_data_reg, half_reg, color_reg);
        end
        else
        begin
            wr_addr = {back, row_t_reg, col_reg};
            wr_data = (col_reg == col_t_reg) ? merge_cell('0, half_reg, color_reg) : '0;
        end
        if (cmd.scan_rd)
        begin
            rd_addr = {front_reg, scan_row_reg, col_reg};
        end
        else
        begin
            rd_addr = {back, row_t_reg, col_t_reg};
        end
    end

    // Frame store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_last_reg <= col_last;
        end
    end

    // Rows never filled since reset or the last clear read as black.
    assign scan_bits = row_valid_reg[{front_reg, scan_row_reg}] ? rd_data_reg : '0;
    assign ra_ext    = RA_W'(scan_row_reg);

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_load)
        begin
            out_bits_reg <= scan_bits;
            out_row_reg  <= ra_ext[ROW_ADDR_W-1:0];
            out_last_reg <= rd_last_reg;
        end
    end

    // Next values of counters, buffer select, row valid bits and output valid.
    always_comb
    begin
        col_next       = col_reg;
        front_next     = front_reg;
        scan_row_next  = scan_row_reg;
        row_valid_next = row_valid_reg;
        out_valid_next = out_valid_reg;
        if (cmd.capture)
        begin
            col_next = '0;
        end
        else if (cmd.scan_rd || cmd.fill_wr)
        begin
            col_next = col_reg + COL_W'(1);
        end
        if (cmd.swap)
        begin
            front_next = ~front_reg;
        end
        if (cmd.scan_done)
        begin
            if (scan_row_reg == ROW_W'(SCAN_ROWS - 1))
            begin
                scan_row_next = '0;
            end
            else
            begin
                scan_row_next = scan_row_reg + ROW_W'(1);
            end
        end
        if (cmd.clear_back)
        begin
            for (int r = 0; r < ROWS_P2; r++)
            begin
                row_valid_next[{back, ROW_W'(r)}] = 1'b0;
            end
        end
        if (cmd.set_row_valid)
        begin
            row_valid_next[{back, row_t_reg}] = 1'b1;
        end
        if (cmd.scan_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            front_reg     <= 1'b0;
            scan_row_reg  <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            front_reg     <= front_next;
            scan_row_reg  <= scan_row_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        status.op        = op_reg;
        status.in_range  = in_range_reg;
        status.row_valid = back_row_valid;
        status.col_last  = col_last;
        status.out_free  = out_free;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_bits  = out_bits_reg;
    assign row_address = out_row_reg;
    assign last        = out_last_reg;

    `LMS_ASSERT_IMPLY(a_load_free, clk, rst_n, cmd.scan_load, !out_valid_reg || out_ready, "scan word loaded over a waiting word")
    `LMS_ASSERT_IMPLY(a_done_last, clk, rst_n, cmd.scan_done, rd_last_reg && cmd.scan_load, "row finished without its last column")
    `LMS_ASSERT_IMPLY(a_rmw_valid, clk, rst_n, cmd.cell_wr, back_row_valid, "cell update into a row that was never filled")

endmodule

/* design/led_matrix_scan_framebuffer.sv */
// A scan tick sends one word per column of the front buffer, one per cycle while scan.ready
// does not stall the output, and holds the block until its last word is loaded. A pixel write
// that first touches a row zeroes that row one cell a cycle, placing the color; else it updates
// one cell in place. Clear and swap finish in decode. One request is worked on at a time.
// Reset (rst_n, asynchronous, active low) clears control state and all row valid bits, so
// both buffers read as black at once; the frame store itself needs no clearing pass.
`timescale 1ns / 1ps
module led_matrix_scan_framebuffer #(
    parameter int PANEL_WIDTH  = lms_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = lms_pkg::PANEL_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lms_req_if.sink    request,
    lms_scan_if.source scan
);
    import lms_pkg::*;

    lms_cmd_t    ctl_cmd;
    lms_status_t dp_status;

    // Sequencing of requests.
    lms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .status   (dp_status),
        .cmd      (ctl_cmd)
    );

    // Frame store and scan output.
    lms_dpath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctl_cmd),
        .status      (dp_status),
        .operation   (request.operation),
        .x           (request.x),
        .y           (request.y),
        .color       (request.color),
        .out_valid   (scan.valid),
        .out_ready   (scan.ready),
        .pixel_bits  (scan.pixel_bits),
        .row_address (scan.row_address),
        .last        (scan.last)
    );

endmodule
